// ===== hw/rtl/mlf_pkg.sv =====
// ----------------------------------------------------------------------------
// mlf_pkg: shared types and constants of the ladder lowpass filter
// Microcode command fields between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package mlf_pkg;

  // Fraction bits of samples and state words.
  localparam int unsigned FRAC_BITS = 23;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLE_GAIN      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLE_FEEDBACK  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RESONANCE_GAIN = 2'd2;

  // Microcode program length.
  localparam int unsigned STEP_BITS = 5;
  localparam logic [STEP_BITS-1:0] LAST_STEP = 5'd22;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Multiplier operand A (state side).
  typedef enum logic [2:0] {
    A_FRESH,
    A_PREV,
    A_S1,
    A_S2,
    A_S3,
    A_S4,
    A_SQ,
    A_M
  } a_sel_e;

  // Multiplier operand B (coefficient side).
  typedef enum logic [2:0] {
    B_P,
    B_K,
    B_R,
    B_FRESH,
    B_RECIP
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_SUB
  } acc_e;

  // Write-back targets.
  typedef enum logic [3:0] {
    WB_NONE,
    WB_X,
    WB_STG1,
    WB_STG2,
    WB_STG3,
    WB_STG4,
    WB_SQ,
    WB_CU,
    WB_M,
    WB_Q0,
    WB_QC,
    WB_CLIP
  } wb_e;

  typedef struct packed {
    logic   capture;
    a_sel_e a_sel;
    b_sel_e b_sel;
    acc_e   acc;
    wb_e    wb;
  } cmd_t;

  localparam cmd_t CMD_NOP = '{
    capture: 1'b0,
    a_sel:   A_FRESH,
    b_sel:   B_P,
    acc:     ACC_NONE,
    wb:      WB_NONE
  };

endpackage

// ===== hw/rtl/moog_ladder_lowpass_filter_top.sv =====
// ----------------------------------------------------------------------------
// moog_ladder_lowpass_filter_top: four-pole ladder lowpass, fixed point
// Stream in, stream out, one filtered sample per input sample.
// ----------------------------------------------------------------------------
// Each item is one signed audio sample (23 fraction bits). The block forms
// the driven input x = in - r*y4, runs four one-pole sections
// y = p*(new + previous input) - k*(own old output), soft-clips the last one
// as y - y^3/6, and returns it saturated to the sample width. Coefficients
// p, k, r are Q1/Q2/Q3.COEF_FRAC_BITS, written through the register port
// (index 0: pole_gain, 1: pole_feedback, 2: resonance_gain); the user must
// write them only while the block is idle, which it does not enforce. The
// item is taken only in the idle cycle, then a 23-step program runs on a
// single shared multiplier (16 products, plus the rounding, clip and
// divide-by-six write-backs). The result sits in an output register; the
// next item is accepted while it waits, and the program only stalls on its
// last step if the previous result has still not been taken.
module moog_ladder_lowpass_filter_top #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned COEF_FRAC_BITS = 20,
  parameter int unsigned STATE_BITS     = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // slave side; tdata: sample_in
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // master side; tdata: sample_out
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
  // register write port
  input  logic                                   cfg_we_i,
  input  logic [mlf_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [COEF_FRAC_BITS+2:0]              cfg_data_i
);
  import mlf_pkg::*;

  localparam int unsigned DW = ((SAMPLE_BITS + 7) / 8) * 8;

  cmd_t                   cmd;
  logic [SAMPLE_BITS-1:0] sample_out;

  mlf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  mlf_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .STATE_BITS     (STATE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .cmd_i        (cmd),
    .sample_out_o (sample_out)
  );

  // zero fill up to whole bytes
  assign m_axis_tdata = DW'(sample_out);

endmodule

// ===== hw/rtl/mlf_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlf_ctrl: sequencer of the ladder filter
// Runs the fixed microcode program once per item, owns the stream handshake.
// ----------------------------------------------------------------------------
module mlf_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output mlf_pkg::cmd_t cmd_o
);
  import mlf_pkg::*;

  state_e               state_q, state_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic                 out_valid_q, out_valid_d;
  logic                 clip_fire;

  // At most one multiply per step; accumulate reads the registered product.
  function automatic cmd_t ucode(input logic [STEP_BITS-1:0] s);
    cmd_t c;
    c = CMD_NOP;
    unique case (s)
      // resonance feedback r * y4
      5'd0:  begin c.a_sel = A_S4;    c.b_sel = B_R; end
      5'd1:  begin c.a_sel = A_PREV;  c.b_sel = B_P;     c.acc = ACC_LOAD; end
      5'd2:  begin c.a_sel = A_S1;    c.b_sel = B_K;     c.acc = ACC_LOAD; c.wb = WB_X; end
      5'd3:  begin c.a_sel = A_FRESH; c.b_sel = B_P;     c.acc = ACC_SUB; end
      5'd4:  begin c.a_sel = A_S1;    c.b_sel = B_P;     c.wb = WB_STG1; end
      5'd5:  begin c.a_sel = A_S2;    c.b_sel = B_K;     c.acc = ACC_LOAD; end
      5'd6:  begin c.a_sel = A_FRESH; c.b_sel = B_P;     c.acc = ACC_SUB; end
      5'd7:  begin c.a_sel = A_S2;    c.b_sel = B_P;     c.wb = WB_STG2; end
      5'd8:  begin c.a_sel = A_S3;    c.b_sel = B_K;     c.acc = ACC_LOAD; end
      5'd9:  begin c.a_sel = A_FRESH; c.b_sel = B_P;     c.acc = ACC_SUB; end
      5'd10: begin c.a_sel = A_S3;    c.b_sel = B_P;     c.wb = WB_STG3; end
      5'd11: begin c.a_sel = A_S4;    c.b_sel = B_K;     c.acc = ACC_LOAD; end
      5'd12: begin c.a_sel = A_FRESH; c.b_sel = B_P;     c.acc = ACC_SUB; end
      5'd13: c.wb = WB_STG4;
      // soft clip: square, cube, divide by six
      5'd14: begin c.a_sel = A_FRESH; c.b_sel = B_FRESH; end
      5'd15: c.wb = WB_SQ;
      5'd16: begin c.a_sel = A_SQ;    c.b_sel = B_FRESH; end
      5'd17: c.wb = WB_CU;
      5'd18: c.wb = WB_M;
      5'd19: begin c.a_sel = A_M;     c.b_sel = B_RECIP; end
      5'd20: c.wb = WB_Q0;
      5'd21: c.wb = WB_QC;
      5'd22: c.wb = WB_CLIP;
      default: c = CMD_NOP;
    endcase
    return c;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = CMD_NOP;
    in_ready_o = 1'b0;
    clip_fire  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_RUN;
          step_d        = '0;
        end
      end
      ST_RUN: begin
        cmd_o = ucode(step_q);
        if (step_q == LAST_STEP) begin
          // final write lands in the output register: wait until it is free
          if (!out_valid_q || out_ready_i) begin
            clip_fire = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            cmd_o.wb = WB_NONE;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = clip_fire | (out_valid_q & ~out_ready_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/mlf_dp.sv =====
// ----------------------------------------------------------------------------
// mlf_dp: datapath of the ladder filter
// One shared signed multiplier, accumulator, filter state and coefficients.
// ----------------------------------------------------------------------------
module mlf_dp #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned COEF_FRAC_BITS = 20,
  parameter int unsigned STATE_BITS     = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mlf_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [COEF_FRAC_BITS+2:0]            cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in_i,
  input  mlf_pkg::cmd_t                        cmd_i,
  output logic [SAMPLE_BITS-1:0]               sample_out_o
);
  import mlf_pkg::*;

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned CF   = COEF_FRAC_BITS;
  localparam int unsigned SW   = STATE_BITS;
  localparam int unsigned AW   = SW;
  localparam int unsigned BW   = (SW > CF + 4) ? SW : CF + 4;
  localparam int unsigned MW   = AW + BW;
  localparam int unsigned ACCW = MW + 2;

  localparam logic signed [ACCW-1:0] HALF_C = ACCW'(1) <<< (CF - 1);
  localparam logic signed [ACCW-1:0] HALF_F = ACCW'(1) <<< (FRAC_BITS - 1);
  // floor(2^(SW-1) / 3): divide by three through the multiplier
  localparam logic [BW-1:0] RECIP = BW'((64'd1 << (SW - 1)) / 64'd3);

  // coefficients
  logic        [CF:0]   pg_q;
  logic signed [CF+1:0] pk_q;
  logic        [CF+2:0] rg_q;

  // filter state
  logic signed [SW-1:0] prev_q, s1_q, s2_q, s3_q, s4_q;

  // working registers
  logic signed [SB-1:0]   sample_q;
  logic signed [SW-1:0]   fresh_q, sq_q, cu_q;
  logic        [SW-2:0]   m_q, q0_q, t3_q, q_q;
  logic                   neg_q;
  logic signed [MW-1:0]   prod_q, prod_d;
  logic signed [ACCW-1:0] acc_q;
  logic        [SB-1:0]   out_q;

  logic signed [AW-1:0]   a_op;
  logic signed [BW-1:0]   b_op;
  logic signed [ACCW-1:0] prod_x, stg_sum, stg_val, x_sum, pw_sum, pw_val, clip_sum;
  logic signed [SW-1:0]   stg_st, x_st, pw_st, clip_st;
  logic        [SW-1:0]   cu_u, n_val;
  logic        [SW-2:0]   q0_val, diff;
  logic        [SB-1:0]   out_d;

  function automatic logic signed [SW-1:0] sat_st(input logic signed [ACCW-1:0] v);
    logic [ACCW-SW:0] hi_bits;
    hi_bits = v[ACCW-1:SW-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      return v[SW-1:0];
    end else if (v[ACCW-1]) begin
      return {1'b1, {(SW-1){1'b0}}};
    end else begin
      return {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  // operand selection
  always_comb begin
    unique case (cmd_i.a_sel)
      A_FRESH: a_op = fresh_q;
      A_PREV:  a_op = prev_q;
      A_S1:    a_op = s1_q;
      A_S2:    a_op = s2_q;
      A_S3:    a_op = s3_q;
      A_S4:    a_op = s4_q;
      A_SQ:    a_op = sq_q;
      A_M:     a_op = $signed({1'b0, m_q});
      default: a_op = fresh_q;
    endcase
    unique case (cmd_i.b_sel)
      B_P:     b_op = $signed(BW'(pg_q));
      B_K:     b_op = BW'(pk_q);
      B_R:     b_op = $signed(BW'(rg_q));
      B_FRESH: b_op = BW'(fresh_q);
      B_RECIP: b_op = $signed(RECIP);
      default: b_op = $signed(BW'(pg_q));
    endcase
    prod_d = a_op * b_op;
  end

  // write-back arithmetic
  always_comb begin
    prod_x  = ACCW'(prod_q);
    // one-pole: acc holds half + p*old - k*own, last product is p*new
    stg_sum = acc_q + prod_x;
    stg_val = stg_sum >>> CF;
    stg_st  = sat_st(stg_val);
    // driven input: acc holds half + r*y4
    x_sum   = ACCW'(sample_q) - (acc_q >>> CF);
    x_st    = sat_st(x_sum);
    // square and cube, rounded to FRAC_BITS
    pw_sum  = prod_x + HALF_F;
    pw_val  = pw_sum >>> FRAC_BITS;
    pw_st   = sat_st(pw_val);
    // (|cu| + 3) / 2, the divide by six then finishes as a divide by three
    cu_u    = cu_q;
    n_val   = cu_q[SW-1] ? (~cu_u + SW'(4)) : (cu_u + SW'(3));
    q0_val  = prod_q[SW-1 +: SW-1];
    // reciprocal estimate is low by at most one
    diff    = m_q - t3_q;
    // y - y^3/6 with the quotient's sign restored
    clip_sum = neg_q ? (ACCW'(fresh_q) + $signed(ACCW'(q_q)))
                     : (ACCW'(fresh_q) - $signed(ACCW'(q_q)));
    clip_st  = sat_st(clip_sum);
  end

  if (SB >= SW) begin : g_out_ext
    assign out_d = SB'(clip_st);
  end else begin : g_out_sat
    logic [SW-SB:0] ohi;
    assign ohi   = clip_st[SW-1:SB-1];
    assign out_d = ((&ohi) || !(|ohi)) ? clip_st[SB-1:0] :
                   (clip_st[SW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});
  end

  // coefficients and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pg_q   <= '0;
      pk_q   <= '0;
      rg_q   <= '0;
      prev_q <= '0;
      s1_q   <= '0;
      s2_q   <= '0;
      s3_q   <= '0;
      s4_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POLE_GAIN:      pg_q <= cfg_data_i[CF:0];
          CFG_POLE_FEEDBACK:  pk_q <= $signed(cfg_data_i[CF+1:0]);
          CFG_RESONANCE_GAIN: rg_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (cmd_i.wb)
        WB_STG1: prev_q <= fresh_q;
        WB_STG2: s1_q   <= fresh_q;
        WB_STG3: s2_q   <= fresh_q;
        WB_STG4: s3_q   <= fresh_q;
        WB_CLIP: s4_q   <= clip_st;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.capture) begin
      sample_q <= sample_in_i;
    end
    unique case (cmd_i.acc)
      ACC_LOAD: acc_q <= prod_x + HALF_C;
      ACC_SUB:  acc_q <= acc_q - prod_x;
      default: ;
    endcase
    unique case (cmd_i.wb)
      WB_X:    fresh_q <= x_st;
      WB_STG1, WB_STG2, WB_STG3, WB_STG4: fresh_q <= stg_st;
      WB_SQ:   sq_q <= pw_st;
      WB_CU:   cu_q <= pw_st;
      WB_M: begin
        m_q   <= n_val[SW-1:1];
        neg_q <= cu_q[SW-1];
      end
      WB_Q0: begin
        q0_q <= q0_val;
        t3_q <= q0_val + {q0_val[SW-3:0], 1'b0};
      end
      WB_QC:   q_q <= q0_q + (SW-1)'(diff >= (SW-1)'(3));
      WB_CLIP: out_q <= out_d;
      default: ;
    endcase
  end

  assign sample_out_o = out_q;

endmodule

// ===== hw/rtl/mlf_chk.sv =====
// ----------------------------------------------------------------------------
// mlf_chk: port-level checks of the ladder filter
// Bound to the top level; watches handshakes and item timing.
// ----------------------------------------------------------------------------
module mlf_chk #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // program is 23 steps: the input is still held off on its last step
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> ##23 !s_axis_tready)
    else $error("item accepted before the previous one finished");

  // a new result only shows up as the sequencer returns to idle
  a_result_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $rose(s_axis_tready))
    else $error("result appeared outside the end of a run");

endmodule

bind moog_ladder_lowpass_filter_top mlf_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mlf_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
